// File: rtl/pidaw_pkg.sv
`timescale 1ns / 1ps

package pidaw_pkg;

   // Field widths
   localparam int DATA_W    = 16;
   localparam int ERR_W     = 17;
   localparam int DIFF_W    = 18;
   localparam int EFF_W     = 17;
   localparam int CSR_IDX_W = 3;

   // Shared multiplier operand and product widths
   localparam int MUL_W  = 20;
   localparam int PROD_W = 2 * MUL_W;

   // Error sum is fed to the multiplier in slices of this width
   localparam int CHUNK_W       = 16;
   localparam int SUM_WIDTH_DEF = 32;

   // Setpoint after reset: 25.5 in Q8.8
   localparam logic signed [DATA_W-1:0] TARGET_RESET = 16'sd6528;

   // Raw effort (Q16.16) at which integration is backed out: 255.0
   localparam int LIMIT_RAW = 16711680;
   // Smallest positive raw effort whose scaled, rounded value exceeds 255.0
   localparam int POS_CLAMP_RAW = 27853014;
   // Final effort limit in Q8.8
   localparam int EFFORT_MAX = 65280;
   // Smallest positive effort that a backed-out step can give
   localparam int HOLD_MIN_EFFORT = 39168;

   // Rounding of Q16.16 to Q8.8
   localparam int ROUND_HALF = 128;
   localparam int FRAC_DROP  = 8;

   // Positive path: q = floor(floor((3*raw + 640) / 256) / 5)
   localparam int POS_RAW_W    = 25;
   localparam int SCALED_W     = 27;
   localparam int Y_W          = SCALED_W - FRAC_DROP;
   localparam int POS_BIAS     = 640;
   localparam int RECIP5       = 419431;
   localparam int RECIP5_SHIFT = 21;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_GAIN_P = 3'd1,
      CSR_GAIN_I = 3'd2,
      CSR_GAIN_D = 3'd3,
      CSR_TARGET = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                     enable;
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic signed [DATA_W-1:0] target;
   } cfg_type;

endpackage

// File: rtl/pidaw_if.sv
`timescale 1ns / 1ps

// Sample channel
interface pidaw_req_if;
   import pidaw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// Effort channel
interface pidaw_rsp_if;
   import pidaw_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [EFF_W-1:0] effort;
   logic                    windup_hold;
   logic                    clamped;
   modport source (output valid, output effort, output windup_hold, output clamped,
                   input ready);
   modport sink   (input valid, input effort, input windup_hold, input clamped,
                   output ready);
endinterface

// Register write channel
interface pidaw_csr_if;
   import pidaw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/pidaw_csr.sv
`timescale 1ns / 1ps

module pidaw_csr (
   input  logic              clock,
   input  logic              reset,
   pidaw_csr_if.sink         csr_bus,
   output pidaw_pkg::cfg_type cfg,
   output logic              clear_state
);
   import pidaw_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write_en;

   assign csr_bus.ready = 1'b1;
   assign write_en      = csr_bus.valid && csr_bus.ready;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in      = cfg_ff;
      clear_state = 1'b0;
      if (write_en) begin
         case (csr_index_type'(csr_bus.index))
            CSR_ENABLE: begin
               cfg_in.enable = csr_bus.data[0];
               clear_state   = 1'b1;
            end
            CSR_GAIN_P: cfg_in.gain_p = signed'(csr_bus.data);
            CSR_GAIN_I: cfg_in.gain_i = signed'(csr_bus.data);
            CSR_GAIN_D: cfg_in.gain_d = signed'(csr_bus.data);
            CSR_TARGET: cfg_in.target = signed'(csr_bus.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable <= 1'b0;
         cfg_ff.gain_p <= '0;
         cfg_ff.gain_i <= '0;
         cfg_ff.gain_d <= '0;
         cfg_ff.target <= TARGET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pidaw_mul.sv
`timescale 1ns / 1ps

module pidaw_mul (
   input  logic                                 clock,
   input  logic signed [pidaw_pkg::MUL_W-1:0]   op_a,
   input  logic signed [pidaw_pkg::MUL_W-1:0]   op_b,
   output logic signed [pidaw_pkg::PROD_W-1:0]  prod
);
   import pidaw_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   // Signed multiply, product registered
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// File: rtl/pid_controller_antiwindup.sv
`timescale 1ns / 1ps
// Channel   Interface      Role    Payload
// req_bus   pidaw_req_if   sink    sample (s16 Q8.8)
// rsp_bus   pidaw_rsp_if   source  effort (s17 Q8.8), windup_hold, clamped
// csr_bus   pidaw_csr_if   sink    index (3 bit), data (16 bit)
//
// Enabled, an item runs through ERR, MUL_P, MUL_D, one MUL_I per 16-bit slice of the
// sum, DRAIN, LIMIT, DIV and FIN: one 20x20 multiplier serves the
// P and D terms, each 16-bit slice of the error sum and the divide by five.
// Disabled, the sequencer goes straight from IDLE to FIN with a zero result.
// Synchronous reset clears the sequencer, result valid, registers and state.
// The result register frees the input side: a new sample is taken while a
// result still waits; only the final step stalls when the result is not taken.

module pid_controller_antiwindup #(
   parameter int SUM_WIDTH = pidaw_pkg::SUM_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pidaw_req_if.sink    req_bus,
   pidaw_rsp_if.source  rsp_bus,
   pidaw_csr_if.sink    csr_bus
);
   import pidaw_pkg::*;

   localparam int NCHUNK = (SUM_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int PAD_W  = NCHUNK * CHUNK_W;
   localparam int ACC_W  = SUM_WIDTH + 18;
   localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int QN_W   = ACC_W - FRAC_DROP;

   localparam logic signed [ACC_W-1:0] LIM_HI    = ACC_W'(LIMIT_RAW);
   localparam logic signed [ACC_W-1:0] LIM_LO    = -ACC_W'(LIMIT_RAW);
   localparam logic signed [ACC_W-1:0] POS_CLAMP = ACC_W'(POS_CLAMP_RAW);
   localparam logic signed [QN_W-1:0]  QN_MIN    = -QN_W'(EFFORT_MAX);
   localparam logic signed [EFF_W-1:0] EFF_HI    = EFF_W'(EFFORT_MAX);
   localparam logic signed [EFF_W-1:0] EFF_LO    = -EFF_W'(EFFORT_MAX);
   localparam logic [CNT_W-1:0]        LAST_CHUNK = CNT_W'(NCHUNK - 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_ERR   = 9'b000000010,
      ST_MUL_P = 9'b000000100,
      ST_MUL_D = 9'b000001000,
      ST_MUL_I = 9'b000010000,
      ST_DRAIN = 9'b000100000,
      ST_LIMIT = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_FIN   = 9'b100000000
   } state_type;

   cfg_type cfg;
   logic    clear_state;

   state_type state_ff, state_in;

   // Controller state
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [ERR_W-1:0]     prev_ff;

   // Per-item working registers
   logic                        off_ff;
   logic signed [ERR_W-1:0]     err_ff;
   logic signed [DIFF_W-1:0]    diff_ff;
   logic signed [SUM_WIDTH-1:0] sum_new_ff;
   logic [CNT_W-1:0]            chunk_ff;
   logic [CNT_W-1:0]            pend_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic                        hold_ff;
   logic                        pos_ff;
   logic                        big_ff;
   logic                        neg_clamp_ff;
   logic signed [EFF_W-1:0]     neg_q_ff;
   logic [Y_W-1:0]              y_ff;

   // Result register
   logic                        rsp_valid_ff;
   logic signed [EFF_W-1:0]     effort_ff;
   logic                        hold_out_ff;
   logic                        clamped_ff;

   logic                        req_fire;
   logic                        fin_go;
   logic signed [MUL_W-1:0]     op_a;
   logic signed [MUL_W-1:0]     op_b;
   logic signed [PROD_W-1:0]    prod;

   logic signed [ERR_W-1:0]     err_new;
   logic signed [SUM_WIDTH:0]   sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_sat;
   logic signed [PAD_W-1:0]     sum_pad;
   logic [CHUNK_W-1:0]          chunk;
   logic                        chunk_last;
   logic signed [ACC_W-1:0]     prod_ext;
   logic signed [ACC_W-1:0]     rnd;
   logic signed [QN_W-1:0]      qn;
   logic [POS_RAW_W-1:0]        raw_low;
   logic [SCALED_W-1:0]         scaled;
   logic signed [EFF_W-1:0]     q_pos;
   logic signed [EFF_W-1:0]     effort_res;
   logic                        clamped_res;

   pidaw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_bus     (csr_bus),
      .cfg         (cfg),
      .clear_state (clear_state)
   );

   pidaw_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign fin_go        = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_bus.ready);

   // Error and saturating sum
   assign err_new  = ERR_W'(cfg.target) - ERR_W'(req_bus.sample);
   assign sum_wide = (SUM_WIDTH+1)'(sum_ff) + (SUM_WIDTH+1)'(err_ff);
   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_WIDTH-1:0];
      end
   end

   // Slice of the new sum for the integral product; only the top slice is signed
   assign sum_pad    = PAD_W'(sum_new_ff);
   assign chunk      = sum_pad[CHUNK_W*chunk_ff +: CHUNK_W];
   assign chunk_last = (chunk_ff == LAST_CHUNK);

   // Multiplier operand select; the divide operands stay on through the final
   // step so the quotient holds while the result waits
   always_comb begin
      case (state_ff)
         ST_MUL_P: begin
            op_a = MUL_W'(signed'(cfg.gain_p));
            op_b = MUL_W'(err_ff);
         end
         ST_MUL_D: begin
            op_a = MUL_W'(signed'(cfg.gain_d));
            op_b = MUL_W'(diff_ff);
         end
         ST_MUL_I: begin
            op_a = MUL_W'(signed'(cfg.gain_i));
            op_b = {{(MUL_W-CHUNK_W){chunk_last & chunk[CHUNK_W-1]}}, chunk};
         end
         ST_DIV, ST_FIN: begin
            op_a = MUL_W'(y_ff);
            op_b = MUL_W'(RECIP5);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Product aligned to its slice position
   assign prod_ext = ACC_W'(prod) <<< (CHUNK_W * pend_ff);

   // Limit stage: rounding of a negative effort, 3/5 scaling input of a positive one
   assign rnd     = acc_ff + ACC_W'(ROUND_HALF);
   assign qn      = rnd[ACC_W-1:FRAC_DROP];
   assign raw_low = acc_ff[POS_RAW_W-1:0];
   assign scaled  = SCALED_W'({raw_low, 1'b0}) + SCALED_W'(raw_low) + SCALED_W'(POS_BIAS);

   // Final effort select
   assign q_pos = prod[RECIP5_SHIFT +: EFF_W];
   always_comb begin
      if (off_ff) begin
         effort_res  = '0;
         clamped_res = 1'b0;
      end else if (!pos_ff) begin
         effort_res  = neg_q_ff;
         clamped_res = neg_clamp_ff;
      end else if (big_ff) begin
         effort_res  = EFF_HI;
         clamped_res = 1'b1;
      end else begin
         effort_res  = q_pos;
         clamped_res = 1'b0;
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire) state_in = cfg.enable ? ST_ERR : ST_FIN;
         ST_ERR:   state_in = ST_MUL_P;
         ST_MUL_P: state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_MUL_I;
         ST_MUL_I: if (chunk_last) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_DIV;
         ST_DIV:   state_in = ST_FIN;
         ST_FIN:   if (fin_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            off_ff <= !cfg.enable;
            err_ff <= err_new;
         end
         ST_ERR: begin
            diff_ff    <= DIFF_W'(prev_ff) - DIFF_W'(err_ff);
            sum_new_ff <= sum_sat;
         end
         ST_MUL_P: begin
            acc_ff   <= '0;
            pend_ff  <= '0;
            chunk_ff <= '0;
         end
         ST_MUL_D: begin
            acc_ff  <= acc_ff + prod_ext;
            pend_ff <= '0;
         end
         ST_MUL_I: begin
            acc_ff   <= acc_ff + prod_ext;
            pend_ff  <= chunk_ff;
            chunk_ff <= chunk_ff + CNT_W'(1);
         end
         ST_DRAIN: begin
            acc_ff <= acc_ff + prod_ext;
         end
         ST_LIMIT: begin
            hold_ff      <= (acc_ff >= LIM_HI) || (acc_ff <= LIM_LO);
            pos_ff       <= !acc_ff[ACC_W-1] && (acc_ff != '0);
            big_ff       <= (acc_ff >= POS_CLAMP);
            neg_clamp_ff <= (qn < QN_MIN);
            neg_q_ff     <= (qn < QN_MIN) ? EFF_LO : qn[EFF_W-1:0];
            y_ff         <= scaled[SCALED_W-1:FRAC_DROP];
         end
         default: ;
      endcase
   end

   // Controller state: cleared on an enable write, committed when the result enters the result register
   always_ff @(posedge clock) begin
      if (reset || clear_state) begin
         sum_ff  <= '0;
         prev_ff <= '0;
      end else if (fin_go && !off_ff) begin
         sum_ff  <= hold_ff ? sum_ff : sum_new_ff;
         prev_ff <= err_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         effort_ff   <= effort_res;
         hold_out_ff <= !off_ff && hold_ff;
         clamped_ff  <= clamped_res;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.effort      = effort_ff;
   assign rsp_bus.windup_hold = hold_out_ff;
   assign rsp_bus.clamped     = clamped_ff;

endmodule

// File: rtl/pidaw_checker.sv
`timescale 1ns / 1ps

module pidaw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [pidaw_pkg::EFF_W-1:0]  rsp_effort,
   input logic                                rsp_windup_hold,
   input logic                                rsp_clamped
);
   import pidaw_pkg::*;

   localparam logic signed [EFF_W-1:0] EFF_HI   = EFF_W'(EFFORT_MAX);
   localparam logic signed [EFF_W-1:0] EFF_LO   = -EFF_W'(EFFORT_MAX);
   localparam logic signed [EFF_W-1:0] HOLD_MIN = EFF_W'(HOLD_MIN_EFFORT);

   // One sample at a time: busy straight after a transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("sample taken while previous one in progress");

   // Pending result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_effort)))
      else $error("result dropped or changed while stalled");

   // Effort stays inside the limit
   a_effort_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_effort >= EFF_LO && rsp_effort <= EFF_HI))
      else $error("effort beyond limit");

   // Clamp flag only with effort at the limit
   a_clamp_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clamped) |-> (rsp_effort == EFF_HI || rsp_effort == EFF_LO))
      else $error("clamped flag with effort inside limit");

   // Integration backed out only when the drive is near saturation
   a_hold_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_windup_hold) |-> (rsp_effort >= HOLD_MIN || rsp_effort == EFF_LO))
      else $error("windup hold with small effort");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_effort      (rsp_bus.effort),
   .rsp_windup_hold (rsp_bus.windup_hold),
   .rsp_clamped     (rsp_bus.clamped)
);
